### rtl/jdm_pkg.sv
`default_nettype none

package jdm_pkg;

    // expo curve: y = (n^3 + n) / 2 with n = |x| / 157, all in Q16
    localparam int EXPO_DIV = 157;
    localparam int EXPO_N   = 129;
    localparam int EXPO_W   = 25;
    localparam int W_BITS   = EXPO_W + 2;

    localparam logic [31:0] REPORT_GAP  = 32'd100;
    localparam logic [31:0] TOGGLE_GAP  = 32'd500;
    localparam logic [8:0]  STILL_ZONE  = 9'd10;
    localparam logic [8:0]  BOOST_ABOVE = 9'd80;
    localparam logic [5:0]  TURN_MAX    = 6'd35;
    localparam logic signed [9:0] TURN_HI  = 10'sd35;
    localparam logic signed [9:0] DRIVE_HI = 10'sd127;

    // serial scaler: 8 multiplier bits, 9 quotient bits, divisor 254
    localparam logic [8:0]  DRIVE_OFFSET = 9'd127;
    localparam logic [3:0]  MUL_LAST     = 4'd7;
    localparam logic [3:0]  DIV_LAST     = 4'd8;
    localparam logic [16:0] DIV_TOP      = 17'd65024;

    localparam logic signed [8:0] SPEED_MAX_RST = 9'sd255;
    localparam logic signed [8:0] SPEED_MIN_RST = -9'sd255;
    localparam logic signed [6:0] TURN_TRIM_RST = 7'sd0;

    typedef enum logic [1:0] {
        REG_SPEED_MAX = 2'd0,
        REG_SPEED_MIN = 2'd1,
        REG_TURN_TRIM = 2'd2
    } reg_idx_t;

    typedef logic [EXPO_N-1:0][EXPO_W-1:0] expo_tbl_t;

    // magnitude of the turn term before sign and trim: |x| * y * 5 in Q16
    function automatic expo_tbl_t expo_table();
        expo_tbl_t t;
        longint    n;
        longint    n2;
        longint    n3;
        longint    y;
        t = '0;
        for (int a = 0; a < EXPO_N; a++)
        begin
            n  = (longint'(a) * 65536) / EXPO_DIV;
            n2 = (n * n) / 65536;
            n3 = (n2 * n) / 65536;
            y  = (n3 + n) / 2;
            t[a] = EXPO_W'(longint'(a) * y * 5);
        end
        return t;
    endfunction

    localparam expo_tbl_t EXPO_TBL = expo_table();

    typedef struct packed {
        logic signed [8:0] speed_max;
        logic signed [8:0] speed_min;
        logic signed [6:0] turn_trim;
    } cfg_t;

    typedef struct packed {
        logic [31:0]       time_ms;
        logic signed [7:0] left_y;
        logic signed [7:0] right_x;
        logic signed [7:0] right_y;
        logic              press_up;
        logic              press_left;
        logic              press_right;
        logic              higher_button;
        logic              halted;
    } in_item_t;

    typedef struct packed {
        logic decide;
        logic mix;
    } front_ctl_t;

    typedef struct packed {
        logic              keep;
        logic              halt;
        logic signed [7:0] right_raw;
        logic signed [7:0] left_raw;
    } mix_res_t;

endpackage

`default_nettype wire

### rtl/jdm_report_if.sv
`default_nettype none

interface jdm_report_if;
    logic              valid;
    logic              ready;
    logic [31:0]       time_ms;
    logic signed [7:0] left_y;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
    logic              press_up;
    logic              press_left;
    logic              press_right;
    logic              higher_button;
    logic              halted;

    modport source (
        output valid, time_ms, left_y, right_x, right_y, press_up, press_left,
               press_right, higher_button, halted,
        input  ready
    );

    modport sink (
        input  valid, time_ms, left_y, right_x, right_y, press_up, press_left,
               press_right, higher_button, halted,
        output ready
    );
endinterface

`default_nettype wire

### rtl/jdm_drive_if.sv
`default_nettype none

interface jdm_drive_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] right_speed;
    logic signed [8:0] left_speed;

    modport source (
        output valid, right_speed, left_speed,
        input  ready
    );

    modport sink (
        input  valid, right_speed, left_speed,
        output ready
    );
endinterface

`default_nettype wire

### rtl/jdm_regs.sv
`default_nettype none

module jdm_regs
    import jdm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_max <= SPEED_MAX_RST;
            cfg_reg.speed_min <= SPEED_MIN_RST;
            cfg_reg.turn_trim <= TURN_TRIM_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SPEED_MAX: cfg_reg.speed_max <= pwdata[8:0];
                REG_SPEED_MIN: cfg_reg.speed_min <= pwdata[8:0];
                REG_TURN_TRIM: cfg_reg.turn_trim <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SPEED_MAX: prdata = {{23{cfg_reg.speed_max[8]}}, cfg_reg.speed_max};
            REG_SPEED_MIN: prdata = {{23{cfg_reg.speed_min[8]}}, cfg_reg.speed_min};
            REG_TURN_TRIM: prdata = {{25{cfg_reg.turn_trim[6]}}, cfg_reg.turn_trim};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/jdm_front.sv
`default_nettype none

module jdm_front
    import jdm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire front_ctl_t        ctl,
    input  wire in_item_t          item,
    input  wire logic signed [6:0] turn_trim,
    output mix_res_t               res
);

    function automatic logic [8:0] abs9(input logic signed [8:0] v);
        return v[8] ? 9'(-v) : 9'(v);
    endfunction

    function automatic logic signed [7:0] clamp_drive(input logic signed [9:0] v);
        logic signed [7:0] r;
        if (v > DRIVE_HI)
            r = 8'(DRIVE_HI);
        else if (v < -DRIVE_HI)
            r = 8'(-DRIVE_HI);
        else
            r = v[7:0];
        return r;
    endfunction

    function automatic logic signed [6:0] clamp_turn(input logic signed [9:0] v);
        logic signed [6:0] r;
        if (v > TURN_HI)
            r = 7'(TURN_HI);
        else if (v < -TURN_HI)
            r = 7'(-TURN_HI);
        else
            r = v[6:0];
        return r;
    endfunction

    logic [31:0] last_update_reg;
    logic [31:0] last_flip_reg;
    logic [31:0] last_mode_reg;
    logic        reversed_reg;
    logic        two_stick_reg;
    logic        keep_reg;
    logic        halt_reg;
    logic signed [W_BITS-1:0] w_reg;
    logic signed [7:0] right_raw_reg;
    logic signed [7:0] left_raw_reg;

    // report filter, toggle debounce and expo lookup
    logic [31:0] upd_gap;
    logic [31:0] flip_gap;
    logic [31:0] mode_gap;
    logic        accept;
    logic        flip_ok;
    logic        mode_ok;
    logic [7:0]  ax;
    logic [EXPO_W-1:0] p;
    logic signed [EXPO_W:0]   sp;
    logic signed [W_BITS-1:0] w_next;

    assign upd_gap  = item.time_ms - last_update_reg;
    assign flip_gap = item.time_ms - last_flip_reg;
    assign mode_gap = item.time_ms - last_mode_reg;
    assign accept   = upd_gap > REPORT_GAP;
    assign flip_ok  = flip_gap > TOGGLE_GAP;
    assign mode_ok  = mode_gap > TOGGLE_GAP;

    assign ax     = item.right_x[7] ? 8'(-item.right_x) : 8'(item.right_x);
    assign p      = EXPO_TBL[ax];
    assign sp     = item.right_x[7] ? -$signed({1'b0, p}) : $signed({1'b0, p});
    assign w_next = $signed({sp[EXPO_W], sp})
                  + $signed({{4{turn_trim[6]}}, turn_trim, 16'd0});

    // mixing from the updated mode bits
    logic              w_neg;
    logic [W_BITS-1:0] wm;
    logic [10:0]       hm;
    logic [5:0]        tmag;
    logic signed [6:0] turn;
    logic signed [7:0] ty;
    logic signed [8:0] ty9;
    logic signed [8:0] sy0;
    logic signed [8:0] ry9;
    logic              still;
    logic signed [8:0] sy;
    logic [8:0]        asy;
    logic              pivot;
    logic              boost;
    logic signed [7:0] rxc;
    logic signed [9:0] t10;
    logic signed [9:0] t5;
    logic signed [9:0] tb;
    logic signed [6:0] turn_f;
    logic signed [9:0] rsum;
    logic signed [9:0] lsum;
    logic signed [7:0] right_raw_next;
    logic signed [7:0] left_raw_next;

    // turn = -trunc(w / 2^16), clamped
    assign w_neg = w_reg[W_BITS-1];
    assign wm    = w_neg ? W_BITS'(-w_reg) : W_BITS'(w_reg);
    assign hm    = wm[W_BITS-1:16];
    assign tmag  = (hm > 11'(TURN_MAX)) ? TURN_MAX : hm[5:0];
    assign turn  = w_neg ? $signed({1'b0, tmag}) : -$signed({1'b0, tmag});

    assign ty    = two_stick_reg ? item.left_y : item.right_y;
    assign ty9   = {ty[7], ty};
    assign sy0   = reversed_reg ? -ty9 : ty9;
    assign ry9   = {item.right_y[7], item.right_y};
    assign still = two_stick_reg && (abs9(sy0) < STILL_ZONE) && (abs9(ry9) < STILL_ZONE);
    assign sy    = still ? 9'sd0 : sy0;
    assign asy   = abs9(sy);
    assign pivot = two_stick_reg && (asy < STILL_ZONE);
    assign boost = two_stick_reg && (asy > BOOST_ABOVE);
    assign rxc   = clamp_drive({{2{item.right_x[7]}}, item.right_x});

    // boost: trunc(turn * 5 / 2)
    assign t10    = {{3{turn[6]}}, turn};
    assign t5     = (t10 <<< 2) + t10;
    assign tb     = (t5 + (t5[9] ? 10'sd1 : 10'sd0)) >>> 1;
    assign turn_f = boost ? clamp_turn(tb) : turn;

    assign rsum = {sy[8], sy} - {{3{turn_f[6]}}, turn_f};
    assign lsum = {sy[8], sy} + {{3{turn_f[6]}}, turn_f};

    assign right_raw_next = pivot ? rxc  : clamp_drive(rsum);
    assign left_raw_next  = pivot ? -rxc : clamp_drive(lsum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_update_reg <= '0;
            last_flip_reg   <= '0;
            last_mode_reg   <= '0;
            reversed_reg    <= 1'b0;
            two_stick_reg   <= 1'b0;
            keep_reg        <= 1'b0;
            halt_reg        <= 1'b0;
        end
        else
        begin
            if (ctl.decide)
            begin
                keep_reg <= accept;
                halt_reg <= item.halted;
                w_reg    <= w_next;
                if (accept)
                begin
                    last_update_reg <= item.time_ms;
                    if (!item.halted && !item.higher_button)
                    begin
                        if (item.press_up)
                        begin
                            if (flip_ok)
                            begin
                                reversed_reg  <= !reversed_reg;
                                last_flip_reg <= item.time_ms;
                            end
                        end
                        else if (item.press_left)
                        begin
                            if (mode_ok)
                            begin
                                two_stick_reg <= 1'b1;
                                last_mode_reg <= item.time_ms;
                            end
                        end
                        else if (item.press_right)
                        begin
                            if (mode_ok)
                            begin
                                two_stick_reg <= 1'b0;
                                last_mode_reg <= item.time_ms;
                            end
                        end
                    end
                end
            end
            if (ctl.mix)
            begin
                right_raw_reg <= right_raw_next;
                left_raw_reg  <= left_raw_next;
            end
        end
    end

    assign res.keep      = keep_reg;
    assign res.halt      = halt_reg;
    assign res.right_raw = right_raw_reg;
    assign res.left_raw  = left_raw_reg;

endmodule

`default_nettype wire

### rtl/jdm_scale.sv
`default_nettype none

// maps a raw drive value onto the speed range: one multiplier bit, then one
// quotient bit per cycle
module jdm_scale
    import jdm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic signed [7:0] raw,
    input  wire logic signed [8:0] speed_max,
    input  wire logic signed [8:0] speed_min,
    output logic                   done,
    output logic signed [8:0]      speed
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    state_t      state_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  mp_reg;
    logic [16:0] mc_reg;
    logic [16:0] acc_reg;
    logic [16:0] dv_reg;
    logic [8:0]  q_reg;
    logic        neg_reg;
    logic        done_reg;
    logic signed [8:0] speed_reg;

    logic [8:0]         u9;
    logic signed [9:0]  diff;
    logic [9:0]         mag;
    logic [16:0]        acc_mul_next;
    logic               ge;
    logic [16:0]        acc_div_next;
    logic signed [9:0]  qs;
    logic signed [10:0] s11;
    logic signed [10:0] min11;
    logic signed [10:0] max11;
    logic signed [8:0]  speed_next;

    assign u9   = 9'({raw[7], raw}) + DRIVE_OFFSET;
    assign diff = $signed({speed_max[8], speed_max}) - $signed({speed_min[8], speed_min});
    assign mag  = diff[9] ? 10'(-diff) : 10'(diff);

    assign acc_mul_next = acc_reg + (mp_reg[0] ? mc_reg : 17'd0);
    assign ge           = acc_reg >= dv_reg;
    assign acc_div_next = ge ? (acc_reg - dv_reg) : acc_reg;

    // quotient is a magnitude, so the sign goes on after: truncation toward zero
    assign qs    = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign min11 = {{2{speed_min[8]}}, speed_min};
    assign max11 = {{2{speed_max[8]}}, speed_max};
    assign s11   = $signed({qs[9], qs}) + min11;

    always_comb
    begin
        if (s11 < min11)
            speed_next = speed_min;
        else if (s11 > max11)
            speed_next = speed_max;
        else
            speed_next = s11[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_FIN);
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mp_reg    <= u9[7:0];
                        mc_reg    <= {8'd0, mag[8:0]};
                        acc_reg   <= '0;
                        neg_reg   <= diff[9];
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    acc_reg <= acc_mul_next;
                    mc_reg  <= {mc_reg[15:0], 1'b0};
                    mp_reg  <= {1'b0, mp_reg[7:1]};
                    if (cnt_reg == MUL_LAST)
                    begin
                        cnt_reg   <= '0;
                        dv_reg    <= DIV_TOP;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_DIV:
                begin
                    acc_reg <= acc_div_next;
                    q_reg   <= {q_reg[7:0], ge};
                    dv_reg  <= {1'b0, dv_reg[16:1]};
                    if (cnt_reg == DIV_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_FIN:
                begin
                    speed_reg <= speed_next;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign speed = speed_reg;

endmodule

`default_nettype wire

### rtl/joystick_differential_drive_mixer_unit.sv
// Differential-drive mixer for controller reports.
//
// report: one beat per controller report (time, stick axes, buttons, game-over
// flag). drive: one beat with right and left motor speeds per report that is
// not filtered out. APB port: speed_max at 0x0, speed_min at 0x4, turn_trim
// at 0x8; write only while no report is in flight.
//
// A report is taken in S_IDLE, then decided (filter, toggles, expo lookup)
// in S_DECIDE and mixed in S_MIX. A filtered report goes from S_MIX back to
// S_IDLE, which frees the report port, and gives no drive beat. Otherwise
// both motor values go through a serial scaler (8 shift-add steps, 9
// restoring-divide steps, one final step) and the drive beat is loaded in
// S_OUT; the next report is taken only after that load, so a new report
// waits until the last one is through. A game-over report skips the
// scalers: S_MIX goes straight to S_OUT, which loads its zero beat.
// A finished drive beat sits in the output register; while drive is stalled
// the next report is still taken and processed, and only its final load waits.
// Reset: forward direction, one-stick mode, all timestamps zero, speed range
// -255..255, trim zero, drive empty.
`default_nettype none

module joystick_differential_drive_mixer_unit
    import jdm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    jdm_report_if.sink       report,
    jdm_drive_if.source      drive,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MIX,
        S_SCALE,
        S_OUT
    } state_t;

    state_t   state_reg;
    logic     start_reg;
    logic     out_valid_reg;
    in_item_t item_reg;
    logic signed [8:0] right_out_reg;
    logic signed [8:0] left_out_reg;

    cfg_t       cfg;
    front_ctl_t ctl;
    mix_res_t   res;
    logic       right_done;
    logic       left_done;
    logic signed [8:0] right_spd;
    logic signed [8:0] left_spd;
    logic       take;
    logic       load_out;

    jdm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign ctl.decide = (state_reg == S_DECIDE);
    assign ctl.mix    = (state_reg == S_MIX);

    jdm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .item      (item_reg),
        .turn_trim (cfg.turn_trim),
        .res       (res)
    );

    jdm_scale u_scale_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .raw       (res.right_raw),
        .speed_max (cfg.speed_max),
        .speed_min (cfg.speed_min),
        .done      (right_done),
        .speed     (right_spd)
    );

    jdm_scale u_scale_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .raw       (res.left_raw),
        .speed_max (cfg.speed_max),
        .speed_min (cfg.speed_min),
        .done      (left_done),
        .speed     (left_spd)
    );

    assign report.ready = (state_reg == S_IDLE);
    assign take         = report.valid && report.ready;
    assign load_out     = (state_reg == S_OUT) && (!out_valid_reg || drive.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= (state_reg == S_MIX) && res.keep && !res.halt;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (drive.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        item_reg.time_ms       <= report.time_ms;
                        item_reg.left_y        <= report.left_y;
                        item_reg.right_x       <= report.right_x;
                        item_reg.right_y       <= report.right_y;
                        item_reg.press_up      <= report.press_up;
                        item_reg.press_left    <= report.press_left;
                        item_reg.press_right   <= report.press_right;
                        item_reg.higher_button <= report.higher_button;
                        item_reg.halted        <= report.halted;
                        state_reg              <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    if (!res.keep)
                        state_reg <= S_IDLE;
                    else if (res.halt)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    if (right_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (load_out)
                    begin
                        right_out_reg <= res.halt ? 9'sd0 : right_spd;
                        left_out_reg  <= res.halt ? 9'sd0 : left_spd;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.right_speed = right_out_reg;
    assign drive.left_speed  = left_out_reg;

    // both lanes start together and run the same step count
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        right_done == left_done)
        else $error("scaler lanes out of step");

    a_done_in_scale: assert property (@(posedge clk) disable iff (!rst_n)
        right_done |-> (state_reg == S_SCALE))
        else $error("scaler finished outside the scale phase");

    a_start_after_mix: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> $past(state_reg == S_MIX))
        else $error("scaler started without a mixed report");

    // game over skips the scalers and goes straight to the output beat
    a_halt_skips_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX && res.keep && res.halt) |=> (state_reg == S_OUT))
        else $error("halted report did not go straight to output");

endmodule

`default_nettype wire

### tb/sv/drive_speed_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module drive_speed_checker
    import jdm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    jdm_report_if            report,
    jdm_drive_if             drive,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               mismatches,
    output int               pending,
    output int               reports_taken,
    output int               reports_dropped,
    output int               beats_checked
);

    localparam logic [31:0] GAP_REPORT_MS = 32'd100;
    localparam logic [31:0] GAP_TOGGLE_MS = 32'd500;
    localparam longint      STILL_LIM     = 10;
    localparam longint      BOOST_LIM     = 80;
    localparam longint      STEER_LIM     = 35;
    localparam longint      DRIVE_LIM     = 127;
    localparam longint      EXPO_SPAN     = 157;
    localparam longint      Q16_ONE       = 65536;

    typedef struct packed {
        logic signed [8:0] right_speed;
        logic signed [8:0] left_speed;
    } drive_beat_t;

    drive_beat_t speeds_due[$];

    logic signed [8:0] speed_hi;
    logic signed [8:0] speed_lo;
    logic signed [6:0] steer_trim;

    logic [31:0] stamp_accept;
    logic [31:0] stamp_flip;
    logic [31:0] stamp_mode;
    logic        dir_reversed;
    logic        dual_stick;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // cubic expo on the stick, gain of 5, trim, then negated; every step truncates
    function automatic longint steer_curve(input logic signed [7:0] stick);
        longint sx;
        longint a;
        longint n;
        longint n2;
        longint n3;
        longint y;
        longint v;
        sx = longint'($signed(stick));
        a  = magnitude(sx);
        n  = (a * Q16_ONE) / EXPO_SPAN;
        n2 = (n * n) / Q16_ONE;
        n3 = (n2 * n) / Q16_ONE;
        y  = (n3 + n) / 2;
        v  = a * y * 5;
        if (sx < 0)
            v = -v;
        v = -(v + longint'($signed(steer_trim)) * Q16_ONE);
        return clip(v / Q16_ONE, -STEER_LIM, STEER_LIM);
    endfunction

    // limits are checked low first, which also decides crossed ranges
    function automatic logic signed [8:0] scale_speed(input longint raw);
        longint hi;
        longint lo;
        longint s;
        hi = longint'($signed(speed_hi));
        lo = longint'($signed(speed_lo));
        s  = ((raw + DRIVE_LIM) * (hi - lo)) / (2 * DRIVE_LIM) + lo;
        if (s < lo)
            s = lo;
        else if (s > hi)
            s = hi;
        return 9'(s);
    endfunction

    function automatic bit mix_report(input in_item_t rpt, output drive_beat_t beat);
        logic [31:0] since_accept;
        logic [31:0] since_flip;
        logic [31:0] since_mode;
        longint      throttle;
        longint      steer;
        longint      right_raw;
        longint      left_raw;
        beat         = '0;
        since_accept = rpt.time_ms - stamp_accept;
        since_flip   = rpt.time_ms - stamp_flip;
        since_mode   = rpt.time_ms - stamp_mode;
        if (since_accept <= GAP_REPORT_MS)
            return 1'b0;
        stamp_accept = rpt.time_ms;
        if (rpt.halted)
            return 1'b1;

        // a colour or reset button masks all toggles; else only the first held one counts
        if (!rpt.higher_button)
        begin
            if (rpt.press_up)
            begin
                if (since_flip > GAP_TOGGLE_MS)
                begin
                    dir_reversed = !dir_reversed;
                    stamp_flip   = rpt.time_ms;
                end
            end
            else if (rpt.press_left || rpt.press_right)
            begin
                if (since_mode > GAP_TOGGLE_MS)
                begin
                    dual_stick = rpt.press_left;
                    stamp_mode = rpt.time_ms;
                end
            end
        end

        throttle = dual_stick ? longint'($signed(rpt.left_y)) : longint'($signed(rpt.right_y));
        if (dir_reversed)
            throttle = -throttle;
        if (dual_stick && magnitude(throttle) < STILL_LIM
            && magnitude(longint'($signed(rpt.right_y))) < STILL_LIM)
            throttle = 0;
        steer = steer_curve(rpt.right_x);

        if (dual_stick && magnitude(throttle) < STILL_LIM)
        begin
            // standstill pivot
            right_raw = clip(longint'($signed(rpt.right_x)), -DRIVE_LIM, DRIVE_LIM);
            left_raw  = -right_raw;
        end
        else
        begin
            if (dual_stick && magnitude(throttle) > BOOST_LIM)
                steer = clip((steer * 5) / 2, -STEER_LIM, STEER_LIM);
            right_raw = clip(throttle - steer, -DRIVE_LIM, DRIVE_LIM);
            left_raw  = clip(throttle + steer, -DRIVE_LIM, DRIVE_LIM);
        end
        beat.right_speed = scale_speed(right_raw);
        beat.left_speed  = scale_speed(left_raw);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_beat_t due;
        drive_beat_t fresh;
        in_item_t    rpt;
        if (!rst_n)
        begin
            speeds_due.delete();
            speed_hi        = SPEED_MAX_RST;
            speed_lo        = SPEED_MIN_RST;
            steer_trim      = TURN_TRIM_RST;
            stamp_accept    = '0;
            stamp_flip      = '0;
            stamp_mode      = '0;
            dir_reversed    = 1'b0;
            dual_stick      = 1'b0;
            mismatches      = 0;
            pending         = 0;
            reports_taken   = 0;
            reports_dropped = 0;
            beats_checked   = 0;
        end
        else
        begin
            if (drive.valid && drive.ready)
            begin
                beats_checked++;
                if (speeds_due.size() == 0)
                begin
                    $display("%0t: unexpected drive beat right %0d left %0d", $time,
                             $signed(drive.right_speed), $signed(drive.left_speed));
                    mismatches++;
                end
                else
                begin
                    due = speeds_due.pop_front();
                    if (drive.right_speed !== due.right_speed)
                    begin
                        $display("%0t: right_speed expected %0d actual %0d", $time,
                                 $signed(due.right_speed), $signed(drive.right_speed));
                        mismatches++;
                    end
                    if (drive.left_speed !== due.left_speed)
                    begin
                        $display("%0t: left_speed expected %0d actual %0d", $time,
                                 $signed(due.left_speed), $signed(drive.left_speed));
                        mismatches++;
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SPEED_MAX: speed_hi   = pwdata[8:0];
                    REG_SPEED_MIN: speed_lo   = pwdata[8:0];
                    REG_TURN_TRIM: steer_trim = pwdata[6:0];
                    default: ;
                endcase
            end

            if (report.valid && report.ready)
            begin
                rpt.time_ms       = report.time_ms;
                rpt.left_y        = report.left_y;
                rpt.right_x       = report.right_x;
                rpt.right_y       = report.right_y;
                rpt.press_up      = report.press_up;
                rpt.press_left    = report.press_left;
                rpt.press_right   = report.press_right;
                rpt.higher_button = report.higher_button;
                rpt.halted        = report.halted;
                reports_taken++;
                if (mix_report(rpt, fresh))
                    speeds_due.push_back(fresh);
                else
                    reports_dropped++;
            end
            pending = speeds_due.size();
        end
    end

endmodule

`default_nettype wire

### tb/sv/joystick_differential_drive_mixer_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none

module joystick_differential_drive_mixer_unit_test;
    import jdm_pkg::*;

    // button sets: {up, left, right, higher, halted}
    localparam logic [4:0] NO_KEY     = 5'b00000;
    localparam logic [4:0] KEY_UP     = 5'b10000;
    localparam logic [4:0] KEY_LEFT   = 5'b01000;
    localparam logic [4:0] KEY_RIGHT  = 5'b00100;
    localparam logic [4:0] KEY_HIGHER = 5'b00010;
    localparam logic [4:0] KEY_HALT   = 5'b00001;

    localparam int SETTLE_CYCLES = 30;
    localparam int PHASES        = 7;

    typedef enum int {
        FLOW_OPEN,
        FLOW_LIGHT,
        FLOW_TOGGLE,
        FLOW_HEAVY
    } flow_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    int          reports_taken;
    int          reports_dropped;
    int          beats_checked;
    int          settings_applied;
    logic [31:0] clock_ms;

    jdm_report_if report_ch ();
    jdm_drive_if  drive_ch ();

    joystick_differential_drive_mixer_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .report  (report_ch),
        .drive   (drive_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    drive_speed_checker i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .report          (report_ch),
        .drive           (drive_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatches      (mismatches),
        .pending         (pending),
        .reports_taken   (reports_taken),
        .reports_dropped (reports_dropped),
        .beats_checked   (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** joystick_differential_drive_mixer_unit: FAILED **");
        $finish;
    end

    // drive side stalls on one of four random patterns (open, light, toggle, heavy), redrawn at random intervals
    initial
    begin
        flow_t flow;
        drive_ch.ready <= 1'b0;
        forever
        begin
            flow = flow_t'($urandom_range(0, 3));
            repeat ($urandom_range(16, 160))
            begin
                @(posedge clk);
                case (flow)
                    FLOW_OPEN:   drive_ch.ready <= 1'b1;
                    FLOW_LIGHT:  drive_ch.ready <= ($urandom_range(0, 3) != 0);
                    FLOW_TOGGLE: drive_ch.ready <= !drive_ch.ready;
                    default:     drive_ch.ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    task automatic push_report(input in_item_t rpt);
        report_ch.valid         <= 1'b1;
        report_ch.time_ms       <= rpt.time_ms;
        report_ch.left_y        <= rpt.left_y;
        report_ch.right_x       <= rpt.right_x;
        report_ch.right_y       <= rpt.right_y;
        report_ch.press_up      <= rpt.press_up;
        report_ch.press_left    <= rpt.press_left;
        report_ch.press_right   <= rpt.press_right;
        report_ch.higher_button <= rpt.higher_button;
        report_ch.halted        <= rpt.halted;
        do @(posedge clk); while (!report_ch.ready);
    endtask

    task automatic send_at(input logic [31:0] stamp, input int ly, input int rx, input int ry,
                           input logic [4:0] keys);
        in_item_t rpt;
        rpt.time_ms       = stamp;
        rpt.left_y        = 8'(ly);
        rpt.right_x       = 8'(rx);
        rpt.right_y       = 8'(ry);
        rpt.press_up      = |(keys & KEY_UP);
        rpt.press_left    = |(keys & KEY_LEFT);
        rpt.press_right   = |(keys & KEY_RIGHT);
        rpt.higher_button = |(keys & KEY_HIGHER);
        rpt.halted        = |(keys & KEY_HALT);
        push_report(rpt);
    endtask

    function automatic logic signed [7:0] random_axis();
        int mag;
        mag = 0;
        case ($urandom_range(0, 5))
            0: mag = $urandom_range(0, 9);
            1: mag = $urandom_range(9, 11);
            2: mag = $urandom_range(78, 127);
            3: return $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
            default: return 8'($urandom());
        endcase
        return $urandom_range(0, 1) ? 8'(-mag) : 8'(mag);
    endfunction

    task automatic random_reports(input int count);
        int       burst_left;
        int       gap;
        in_item_t rpt;
        burst_left = 0;
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if ($urandom_range(0, 9) == 0)
                    gap = $urandom_range(20, 60);
                if (gap > 0)
                begin
                    report_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;

            // mostly well spaced reports, some inside the gap filter, a few big jumps
            case ($urandom_range(0, 19))
                0, 1:    clock_ms += $urandom_range(0, 100);
                2:       clock_ms += $urandom_range(0, 1) ? 32'd100 : 32'd101;
                3:       clock_ms = $urandom();
                default: clock_ms += $urandom_range(101, 800);
            endcase
            rpt.time_ms       = clock_ms;
            rpt.left_y        = random_axis();
            rpt.right_x       = random_axis();
            rpt.right_y       = random_axis();
            rpt.press_up      = ($urandom_range(0, 5) == 0);
            rpt.press_left    = ($urandom_range(0, 5) == 0);
            rpt.press_right   = ($urandom_range(0, 5) == 0);
            rpt.higher_button = ($urandom_range(0, 9) == 0);
            rpt.halted        = ($urandom_range(0, 11) == 0);
            push_report(rpt);
        end
    endtask

    // no report in flight: last drive beat taken, then room for a filtered one to drain
    task automatic settle();
        report_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int phase);
        int top;
        int bottom;
        int trim;
        case (phase)
            0:       begin top = -255; bottom =  255; trim =  35; end
            1:       begin top =  255; bottom = -255; trim = -35; end
            2:       begin top =    0; bottom =    0; trim =  -1; end
            3:       begin top =  255; bottom =  255; trim =   0; end
            4:       begin top = -255; bottom = -255; trim =  17; end
            default:
            begin
                top    = $urandom_range(0, 510) - 255;
                bottom = $urandom_range(0, 510) - 255;
                trim   = $urandom_range(0, 70) - 35;
            end
        endcase
        write_reg(REG_SPEED_MAX, top);
        write_reg(REG_SPEED_MIN, bottom);
        write_reg(REG_TURN_TRIM, trim);
        settings_applied++;
    endtask

    task automatic directed_reports();
        send_at(32'd0,    0,    0,    0,    NO_KEY);
        send_at(32'd100,  0,    0,    0,    NO_KEY);
        send_at(32'd101,  0,    0,    127,  NO_KEY);
        send_at(32'd300,  0,    127,  -128, KEY_UP);
        send_at(32'd601,  0,    -128, 0,    KEY_UP);
        send_at(32'd800,  0,    0,    127,  KEY_UP);
        send_at(32'd1000, 5,    100,  3,    KEY_LEFT);
        send_at(32'd1200, -128, 60,   50,   NO_KEY);
        send_at(32'd1400, 50,   -30,  0,    KEY_RIGHT);
        send_at(32'd1600, 9,    -128, 20,   KEY_RIGHT | KEY_HIGHER);
        send_at(32'd1800, 81,   127,  -128, KEY_RIGHT);
        send_at(32'd1900, 127,  127,  127,  KEY_UP | KEY_HALT);
        send_at(32'd2000, 0,    0,    0,    NO_KEY);
        send_at(32'd2001, -1,   -1,   -1,   KEY_UP | KEY_LEFT);
        send_at(32'd2600, 10,   10,   10,   KEY_LEFT);
        send_at(32'd2800, 80,   -10,  9,    NO_KEY);
        send_at(32'd3000, 81,   -9,   0,    NO_KEY);
        send_at(32'hFFFF_FF00, -128, -128, -128, KEY_UP | KEY_LEFT | KEY_RIGHT | KEY_HIGHER);
        // time wraps past zero
        send_at(32'h0000_0010, -10, 1, -9, KEY_RIGHT);
        clock_ms = 32'h0000_0010;
    endtask

    initial
    begin
        settings_applied = 0;
        clock_ms         = '0;
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        report_ch.valid         <= 1'b0;
        report_ch.time_ms       <= '0;
        report_ch.left_y        <= '0;
        report_ch.right_x       <= '0;
        report_ch.right_y       <= '0;
        report_ch.press_up      <= 1'b0;
        report_ch.press_left    <= 1'b0;
        report_ch.press_right   <= 1'b0;
        report_ch.higher_button <= 1'b0;
        report_ch.halted        <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_reports();
        random_reports(60);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            apply_setting(phase);
            random_reports(55);
        end
        settle();

        $display("%0d reports sent, %0d held back by the report gap filter, %0d drive beats checked",
                 reports_taken, reports_dropped, beats_checked);
        $display("speed range and trim taken through %0d settings besides reset, crossed limits too",
                 settings_applied);
        if (mismatches == 0 && pending == 0)
            $display("** joystick_differential_drive_mixer_unit: PASSED **");
        else
            $display("** joystick_differential_drive_mixer_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
